@@ sv/pcbf_pkg.sv @@
// pcbf_pkg: shared types, widths and constants of the point cloud bilateral filter.
// No dependencies; used by every module of the block.
package pcbf_pkg;

  localparam int COORD_W       = 32;
  localparam int NORM_W        = 16;
  localparam int WGT_W         = 16;
  localparam int WSUM_W        = 24;
  localparam int LSUM_W        = 48;
  localparam int MAX_NEIGHBORS = 32;
  localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
  localparam int EXP_DEPTH     = 1024;
  localparam int EXP_AW        = $clog2(EXP_DEPTH);
  localparam logic [31:0] EXP_RATIO = 32'd4228380000;  // about exp(-1/64) in Q0.32
  localparam int Q_DEPTH       = 4;
  localparam int Q_AW          = $clog2(Q_DEPTH);
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_DATA_W     = 160;
  localparam int OUT_DATA_W    = 96;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_D = 1'b0,
    CFG_INV_N = 1'b1
  } cfg_index_t;

  typedef enum logic {
    ITEM_CENTER   = 1'b0,
    ITEM_NEIGHBOR = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t                 kind;
    logic                       last;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
    logic signed [NORM_W-1:0]   nx;
    logic signed [NORM_W-1:0]   ny;
    logic signed [NORM_W-1:0]   nz;
    logic [WGT_W-1:0]           cw;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] inv_d;
    logic [CFG_DATA_W-1:0] inv_n;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_SQ,
    BS_MAG,
    BS_SSQ,
    BS_IXLO,
    BS_IXHI,
    BS_IXSUM,
    BS_RD,
    BS_ACC,
    BS_E0,
    BS_E1,
    BS_DIV,
    BS_OMUL,
    BS_OSAT,
    BS_OUT
  } back_state_t;

endpackage

@@ sv/pcbf_exp_rom.sv @@
// pcbf_exp_rom: exp(-k/64) weight table, filled by a sweep after reset, one read port.
// Depends on pcbf_pkg.
module pcbf_exp_rom (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         busy,
  input  logic [pcbf_pkg::EXP_AW-1:0]  rd_addr,
  output logic [15:0]                  rd_data
);

  logic [15:0]                 mem [pcbf_pkg::EXP_DEPTH];
  logic [pcbf_pkg::EXP_AW-1:0] fill_addr_r;
  logic [32:0]                 a_r, a_nxt;
  logic                        busy_r;
  logic [15:0]                 rd_data_r;
  logic [63:0]                 prod_lo;
  logic [65:0]                 prod_sum;
  logic [33:0]                 entry_sum;

  // a * ratio with a up to 2^32: low 32 bits through the multiplier, top bit as a select
  assign prod_lo   = 64'(a_r[31:0]) * 64'(pcbf_pkg::EXP_RATIO);
  assign prod_sum  = 66'(prod_lo) + (a_r[32] ? {2'b00, pcbf_pkg::EXP_RATIO, 32'h0} : 66'h0)
                   + 66'h8000_0000;
  assign a_nxt     = prod_sum[64:32];
  assign entry_sum = 34'(a_r) + 34'd65536;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      fill_addr_r <= '0;
      a_r         <= 33'h1_0000_0000;
    end else if (busy_r) begin
      a_r         <= a_nxt;
      fill_addr_r <= fill_addr_r + 1'b1;
      if (fill_addr_r == pcbf_pkg::EXP_AW'(pcbf_pkg::EXP_DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[fill_addr_r] <= entry_sum[32:17];
    end
    rd_data_r <= mem[rd_addr];
  end

  assign busy    = busy_r;
  assign rd_data = rd_data_r;

`ifndef SYNTHESIS
  a_fill_once: assert property (@(posedge clk) disable iff (!rst_n) !busy_r |=> !busy_r)
    else $error("table fill restarted");
`endif

endmodule

@@ sv/pcbf_front.sv @@
// pcbf_front: input request acceptance, item decode and the short item queue.
// Depends on pcbf_pkg.
module pcbf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pcbf_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  input  logic                            rom_busy,
  output pcbf_pkg::queue_head_t           head,
  input  logic                            pop
);

  pcbf_pkg::item_t           q_mem_r [pcbf_pkg::Q_DEPTH];
  logic [pcbf_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [pcbf_pkg::Q_AW:0]   cnt_r;
  pcbf_pkg::item_t           item;
  logic                      push;

  always_comb begin
    item.kind = pcbf_pkg::item_kind_t'(in_tuser);
    item.last = in_tlast;
    item.px   = in_tdata[31:0];
    item.py   = in_tdata[63:32];
    item.pz   = in_tdata[95:64];
    item.nx   = in_tdata[111:96];
    item.ny   = in_tdata[127:112];
    item.nz   = in_tdata[143:128];
    item.cw   = in_tdata[159:144];
  end

  assign in_tready = (cnt_r != (pcbf_pkg::Q_AW + 1)'(pcbf_pkg::Q_DEPTH)) && !rom_busy;
  assign push      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= item;
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_mem_r[rd_ptr_r];

endmodule

@@ sv/pcbf_back.sv @@
// pcbf_back: per item sequencer: neighbor weight accumulation, move divide and output stage.
// Depends on pcbf_pkg; reads the weight table in pcbf_exp_rom.
module pcbf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pcbf_pkg::queue_head_t            head,
  output logic                             pop,
  input  pcbf_pkg::cfg_regs_t              cfg,
  output logic [pcbf_pkg::EXP_AW-1:0]      rom_addr,
  input  logic [15:0]                      rom_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pcbf_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tuser
);

  pcbf_pkg::back_state_t state_r, state_nxt;

  // center and sums
  logic signed [31:0]            c_r [3];
  logic signed [15:0]            n_r [3];
  logic [15:0]                   cw_r;
  logic [pcbf_pkg::WSUM_W-1:0]   ws_r;
  logic signed [pcbf_pkg::LSUM_W-1:0] ls_r;
  logic [pcbf_pkg::CNT_W-1:0]    cnt_r;
  logic                          last_r;

  // neighbor datapath
  logic signed [32:0] d_r [3];
  logic [1:0]         ax_r;
  logic [63:0]        dsq_r, ssq_r, plo_d_r, plo_n_r, td_r, tn_r;
  logic signed [50:0] s_r;
  logic [34:0]        m_r;
  logic [pcbf_pkg::EXP_AW-1:0] idx_r;
  logic               inrng_r;

  // emit datapath
  logic [63:0] num_r;
  logic [38:0] den_r;
  logic [38:0] rem_r;
  logic [5:0]  dcnt_r;
  logic [64:0] prod_r;
  logic [31:0] f_r [3];
  logic        moved_r;

  logic        out_valid_r;
  logic [95:0] out_data_r;
  logic        out_moved_r;

  logic        out_load;
  logic        accept_nb;

  // combinational helpers
  logic [31:0]        dmag;
  logic [64:0]        dsq_sum;
  logic signed [48:0] nd;
  logic [49:0]        smag;
  logic [54:0]        idx_sum;
  logic [15:0]        w;
  logic [50:0]        wm;
  logic [47:0]        lmag;
  logic [39:0]        trial;
  logic               ge;
  logic [15:0]        nmag;
  logic [65:0]        off_sum;
  logic signed [52:0] fsum;
  logic signed [52:0] offs;

  assign accept_nb = (cnt_r < pcbf_pkg::CNT_W'(pcbf_pkg::MAX_NEIGHBORS));

  assign dmag    = d_r[ax_r][32] ? 32'(-d_r[ax_r]) : 32'(d_r[ax_r]);
  assign dsq_sum = 65'(dsq_r) + 65'(64'(dmag) * 64'(dmag));
  assign nd      = 49'(n_r[ax_r]) * 49'(d_r[ax_r]);
  assign smag    = s_r[50] ? 50'(-s_r) : 50'(s_r);
  assign idx_sum = 55'(td_r >> 10) + 55'(tn_r >> 10);
  assign w       = inrng_r ? rom_data : 16'h0;
  assign wm      = 51'(w) * 51'(m_r);
  assign lmag    = ls_r[47] ? 48'(-ls_r) : 48'(ls_r);
  assign trial   = {rem_r, num_r[63]};
  assign ge      = (trial >= {1'b0, den_r});
  assign nmag    = n_r[ax_r][15] ? 16'(-n_r[ax_r]) : 16'(n_r[ax_r]);
  assign off_sum = 66'(prod_r) + 66'd8192;
  assign offs    = 53'({1'b0, off_sum[65:14]});
  assign fsum    = (ls_r[47] != n_r[ax_r][15]) ? 53'(c_r[ax_r]) - offs
                                               : 53'(c_r[ax_r]) + offs;

  assign rom_addr = idx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcbf_pkg::BS_IDLE: begin
        if (head.valid) begin
          if (head.item.kind == pcbf_pkg::ITEM_NEIGHBOR && accept_nb) begin
            state_nxt = pcbf_pkg::BS_SQ;
          end else if (head.item.last) begin
            state_nxt = pcbf_pkg::BS_E0;
          end
        end
      end
      pcbf_pkg::BS_SQ:    if (ax_r == 2'd2) state_nxt = pcbf_pkg::BS_MAG;
      pcbf_pkg::BS_MAG:   state_nxt = pcbf_pkg::BS_SSQ;
      pcbf_pkg::BS_SSQ:   state_nxt = pcbf_pkg::BS_IXLO;
      pcbf_pkg::BS_IXLO:  state_nxt = pcbf_pkg::BS_IXHI;
      pcbf_pkg::BS_IXHI:  state_nxt = pcbf_pkg::BS_IXSUM;
      pcbf_pkg::BS_IXSUM: state_nxt = pcbf_pkg::BS_RD;
      pcbf_pkg::BS_RD:    state_nxt = pcbf_pkg::BS_ACC;
      pcbf_pkg::BS_ACC:   state_nxt = last_r ? pcbf_pkg::BS_E0 : pcbf_pkg::BS_IDLE;
      pcbf_pkg::BS_E0:    state_nxt = (ws_r != '0 && ls_r != '0) ? pcbf_pkg::BS_E1
                                                                 : pcbf_pkg::BS_OUT;
      pcbf_pkg::BS_E1:    state_nxt = pcbf_pkg::BS_DIV;
      pcbf_pkg::BS_DIV:   if (dcnt_r == 6'd63) state_nxt = pcbf_pkg::BS_OMUL;
      pcbf_pkg::BS_OMUL:  state_nxt = pcbf_pkg::BS_OSAT;
      pcbf_pkg::BS_OSAT:  state_nxt = (ax_r == 2'd2) ? pcbf_pkg::BS_OUT : pcbf_pkg::BS_OMUL;
      pcbf_pkg::BS_OUT:   if (!out_valid_r || out_tready) state_nxt = pcbf_pkg::BS_IDLE;
      default:            state_nxt = pcbf_pkg::BS_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      pcbf_pkg::BS_IDLE: pop      = head.valid;
      pcbf_pkg::BS_OUT:  out_load = !out_valid_r || out_tready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcbf_pkg::BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // center state and sums (model state, cleared by reset)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        c_r[k] <= '0;
        n_r[k] <= '0;
      end
      cw_r  <= '0;
      ws_r  <= '0;
      ls_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (pop && head.item.kind == pcbf_pkg::ITEM_CENTER) begin
        c_r[0] <= head.item.px;
        c_r[1] <= head.item.py;
        c_r[2] <= head.item.pz;
        n_r[0] <= head.item.nx;
        n_r[1] <= head.item.ny;
        n_r[2] <= head.item.nz;
        cw_r   <= head.item.cw;
        ws_r   <= '0;
        ls_r   <= '0;
        cnt_r  <= '0;
      end else if (state_r == pcbf_pkg::BS_ACC) begin
        ws_r  <= ws_r + pcbf_pkg::WSUM_W'(w);
        ls_r  <= s_r[50] ? ls_r - 48'(wm[50:15]) : ls_r + 48'(wm[50:15]);
        cnt_r <= cnt_r + 1'b1;
      end else if (out_load) begin
        ws_r  <= '0;
        ls_r  <= '0;
        cnt_r <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      pcbf_pkg::BS_IDLE: begin
        last_r <= head.item.last;
        ax_r   <= '0;
        dsq_r  <= '0;
        s_r    <= '0;
        d_r[0] <= 33'(head.item.px) - 33'(c_r[0]);
        d_r[1] <= 33'(head.item.py) - 33'(c_r[1]);
        d_r[2] <= 33'(head.item.pz) - 33'(c_r[2]);
      end
      pcbf_pkg::BS_SQ: begin
        dsq_r <= dsq_sum[64] ? '1 : dsq_sum[63:0];
        s_r   <= s_r + 51'(nd);
        ax_r  <= ax_r + 1'b1;
      end
      pcbf_pkg::BS_MAG:  m_r <= smag[48:14];
      pcbf_pkg::BS_SSQ:  ssq_r <= (m_r[34:32] != '0) ? '1 : 64'(m_r[31:0]) * 64'(m_r[31:0]);
      pcbf_pkg::BS_IXLO: begin
        plo_d_r <= 64'(dsq_r[31:0]) * 64'(cfg.inv_d);
        plo_n_r <= 64'(ssq_r[31:0]) * 64'(cfg.inv_n);
      end
      pcbf_pkg::BS_IXHI: begin
        td_r <= 64'(dsq_r[63:32]) * 64'(cfg.inv_d) + 64'(plo_d_r[63:32]);
        tn_r <= 64'(ssq_r[63:32]) * 64'(cfg.inv_n) + 64'(plo_n_r[63:32]);
      end
      pcbf_pkg::BS_IXSUM: begin
        inrng_r <= (idx_sum < 55'(pcbf_pkg::EXP_DEPTH));
        idx_r   <= idx_sum[pcbf_pkg::EXP_AW-1:0];
      end
      pcbf_pkg::BS_E0: begin
        moved_r <= (ws_r != '0 && ls_r != '0);
        num_r   <= 64'(lmag) * 64'(cw_r);
        for (int k = 0; k < 3; k++) f_r[k] <= c_r[k];
      end
      pcbf_pkg::BS_E1: begin
        // half the divisor added for round half up
        num_r  <= num_r + {26'h0, ws_r, 14'h0};
        den_r  <= {ws_r, 15'h0};
        rem_r  <= '0;
        dcnt_r <= '0;
        ax_r   <= '0;
      end
      pcbf_pkg::BS_DIV: begin
        rem_r  <= ge ? 39'(trial - {1'b0, den_r}) : trial[38:0];
        num_r  <= {num_r[62:0], ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
      pcbf_pkg::BS_OMUL: prod_r <= 65'(num_r[48:0]) * 65'(nmag);
      pcbf_pkg::BS_OSAT: begin
        if (fsum > 53'sd2147483647)       f_r[ax_r] <= 32'h7FFF_FFFF;
        else if (fsum < -53'sd2147483648) f_r[ax_r] <= 32'h8000_0000;
        else                              f_r[ax_r] <= fsum[31:0];
        ax_r <= ax_r + 1'b1;
      end
      pcbf_pkg::BS_OUT: begin
        if (out_load) begin
          out_data_r  <= {f_r[2], f_r[1], f_r[0]};
          out_moved_r <= moved_r;
        end
      end
      default: begin
        ax_r <= ax_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_moved_r;

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pcbf_pkg::CNT_W'(pcbf_pkg::MAX_NEIGHBORS))
    else $error("neighbor count beyond cap");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pcbf_pkg::BS_DIV |-> rem_r < den_r)
    else $error("divider remainder not reduced");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");
`endif

endmodule

@@ sv/point_cloud_bilateral_filter_core.sv @@
// point_cloud_bilateral_filter_core: top level, configuration registers and module wiring.
// Depends on pcbf_pkg, pcbf_exp_rom, pcbf_front and pcbf_back.
//
// Bilateral smoothing of one point at a time. A center request (in_tuser = 0) loads the point,
// its unit normal and curvature weight and clears the sums; neighbor requests (in_tuser = 1)
// each add a weight w = exp(-|d|^2*cd - (n.d)^2*cn) and w*(n.d), and the request with
// in_tlast set produces one result: the point moved along its normal by
// weight*sum(w*s)/sum(w), or the point unchanged with moved = 0 when a sum is zero. Only the
// first 32 neighbors since the last center or result count. After reset the exp table is
// built by a sweep over its 1024 entries, during which in_tready stays low. A four-entry
// queue sits between the input side and the sequencer. In the sequencer a center needs only
// the fetch step; a counted neighbor passes through fetch, three multiply steps of the
// distance, magnitude, squaring, the two index products, the index sum, the table read and
// the accumulate; a request with last then forms the move in the one-bit-per-cycle divider
// (skipped when a sum is zero), plus any wait for out_tready. Results wait in an output
// register.
module point_cloud_bilateral_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // px, py, pz, nx, ny, nz, curv_weight from bit 0 up
  input  logic [pcbf_pkg::IN_DATA_W-1:0]    in_tdata,
  // op
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // fx, fy, fz from bit 0 up
  output logic [pcbf_pkg::OUT_DATA_W-1:0]   out_tdata,
  // moved
  output logic                              out_tuser,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [pcbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcbf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  pcbf_pkg::cfg_regs_t         cfg_r;
  pcbf_pkg::queue_head_t       head;
  logic                        pop;
  logic                        rom_busy;
  logic [pcbf_pkg::EXP_AW-1:0] rom_addr;
  logic [15:0]                 rom_data;

  // both scales reset to 1.0 in Q16.16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_d <= 32'h0001_0000;
      cfg_r.inv_n <= 32'h0001_0000;
    end else if (cfg_we) begin
      case (pcbf_pkg::cfg_index_t'(cfg_index))
        pcbf_pkg::CFG_INV_D: cfg_r.inv_d <= cfg_wdata;
        pcbf_pkg::CFG_INV_N: cfg_r.inv_n <= cfg_wdata;
        default:             cfg_r       <= cfg_r;
      endcase
    end
  end

  pcbf_exp_rom u_rom (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (rom_busy),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  pcbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .rom_busy  (rom_busy),
    .head      (head),
    .pop       (pop)
  );

  pcbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .cfg        (cfg_r),
    .rom_addr   (rom_addr),
    .rom_data   (rom_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
